### sv/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg: shared constants for the sorted run merge block
// Default sizes of the element store and the width of the left run count.
// ----------------------------------------------------------------------------
package srm_pkg;

   // default store geometry
   localparam int STORE_DEPTH   = 64;
   localparam int ELEMENT_WIDTH = 16;

   // left run count register
   localparam int              LEFT_COUNT_W   = 7;
   localparam logic [LEFT_COUNT_W-1:0] LEFT_COUNT_RST = LEFT_COUNT_W'(1);

endpackage

### sv/srm_ifs.sv
// ----------------------------------------------------------------------------
// srm_ifs: channel interfaces of the sorted run merge block
// Valid/ready channels for input words, result words and the register write.
// ----------------------------------------------------------------------------

// input word channel
interface srm_req_if #(
   parameter int WIDTH = srm_pkg::ELEMENT_WIDTH
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] value;
   logic             last_in;

   modport source (output valid, output value, output last_in, input ready);
   modport sink   (input valid, input value, input last_in, output ready);
endinterface

// result word channel
interface srm_rsp_if #(
   parameter int WIDTH = srm_pkg::ELEMENT_WIDTH
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] merged_value;
   logic             last_out;

   modport source (output valid, output merged_value, output last_out, input ready);
   modport sink   (input valid, input merged_value, input last_out, output ready);
endinterface

// left_count register write channel
interface srm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [srm_pkg::LEFT_COUNT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### sv/srm_store.sv
// ----------------------------------------------------------------------------
// srm_store: element store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module srm_store #(
   parameter int DEPTH = srm_pkg::STORE_DEPTH,
   parameter int WIDTH = srm_pkg::ELEMENT_WIDTH,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### sv/sorted_run_merge.sv
// ----------------------------------------------------------------------------
// sorted_run_merge: merge of two sorted runs held in one loaded sub-array
// Sequence: after the word marked last, a prime state sets run end and heads.
// Throughput: loading takes one word per cycle; merging gives one result word
//   per cycle while the sink is ready, set by the two store read ports and the
//   single output register.
// Reset: counts and heads clear, left_count returns to 1, store not cleared.
// ----------------------------------------------------------------------------
module sorted_run_merge #(
   parameter int STORE_DEPTH   = srm_pkg::STORE_DEPTH,
   parameter int ELEMENT_WIDTH = srm_pkg::ELEMENT_WIDTH
) (
   input  logic     clock,
   input  logic     reset,
   srm_req_if.sink  req_if,
   srm_rsp_if.source rsp_if,
   srm_csr_if.sink  csr_if
);

   localparam int AW  = $clog2(STORE_DEPTH);
   localparam int CW  = $clog2(STORE_DEPTH + 1);
   localparam int LCW = srm_pkg::LEFT_COUNT_W;
   localparam int MW  = (CW > LCW) ? CW : LCW;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PRIME,
      ST_MERGE
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           left_head_ff, left_head_in;
   logic [CW-1:0]           right_head_ff, right_head_in;
   logic [CW-1:0]           left_end_ff, left_end_in;
   logic [CW-1:0]           emit_cnt_ff, emit_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ELEMENT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [LCW-1:0]          left_count_ff, left_count_in;

   logic                    req_accept;
   logic                    store_wr;
   logic [ELEMENT_WIDTH-1:0] left_val;
   logic [ELEMENT_WIDTH-1:0] right_val;
   logic                    left_avail;
   logic                    right_avail;
   logic                    take_left;
   logic                    emit;
   logic                    emit_last;

   // element store
   srm_store #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (ELEMENT_WIDTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (store_wr),
      .wr_addr   (count_ff[AW-1:0]),
      .wr_data   (req_if.value),
      .rd_addr_a (left_head_in[AW-1:0]),
      .rd_addr_b (right_head_in[AW-1:0]),
      .rd_data_a (left_val),
      .rd_data_b (right_val)
   );

   // handshakes
   assign req_if.ready = (state_ff == ST_LOAD);
   assign req_accept   = req_if.valid && req_if.ready;
   assign store_wr     = req_accept && (count_ff < CW'(STORE_DEPTH));
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.merged_value = rsp_value_ff;
   assign rsp_if.last_out     = rsp_last_ff;

   // merge pick: heads' data is valid in ST_MERGE
   assign left_avail  = left_head_ff < left_end_ff;
   assign right_avail = right_head_ff < count_ff;
   assign take_left   = (left_avail && right_avail) ? (left_val <= right_val) : left_avail;
   assign emit        = (state_ff == ST_MERGE) && (!rsp_valid_ff || rsp_if.ready);
   assign emit_last   = emit_cnt_ff == (count_ff - CW'(1));

   // next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      left_head_in  = left_head_ff;
      right_head_in = right_head_ff;
      left_end_in   = left_end_ff;
      emit_cnt_in   = emit_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      left_count_in = left_count_ff;

      if (csr_if.valid && csr_if.ready) begin
         left_count_in = csr_if.data;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (store_wr) begin
               count_in = count_ff + CW'(1);
            end
            if (req_accept && req_if.last_in) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            // left run ends at min(left_count, loaded count)
            if (MW'(left_count_ff) < MW'(count_ff)) begin
               left_end_in = CW'(left_count_ff);
            end else begin
               left_end_in = count_ff;
            end
            left_head_in  = '0;
            right_head_in = left_end_in;
            emit_cnt_in   = '0;
            state_in      = ST_MERGE;
         end
         ST_MERGE: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = emit_last;
               if (take_left) begin
                  rsp_value_in = left_val;
                  left_head_in = left_head_ff + CW'(1);
               end else begin
                  rsp_value_in  = right_val;
                  right_head_in = right_head_ff + CW'(1);
               end
               emit_cnt_in = emit_cnt_ff + CW'(1);
               if (emit_last) begin
                  state_in      = ST_LOAD;
                  count_in      = '0;
                  left_head_in  = '0;
                  right_head_in = '0;
                  emit_cnt_in   = '0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         left_head_ff  <= '0;
         right_head_ff <= '0;
         left_end_ff   <= '0;
         emit_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         left_count_ff <= srm_pkg::LEFT_COUNT_RST;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         left_head_ff  <= left_head_in;
         right_head_ff <= right_head_in;
         left_end_ff   <= left_end_in;
         emit_cnt_ff   <= emit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         left_count_ff <= left_count_in;
      end
   end

endmodule
